@@ rtl/core/vmt_pkg.sv @@
// Shared types and constants for the vertex matrix transform
`default_nettype none

package vmt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIM       = 4;
	localparam int NUM_REGS  = 8;
	localparam int COMP_W    = 32;
	localparam int REG_W     = 64;
	localparam int IDX_W     = 3;
	localparam int PROD_W    = 2 * COMP_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;

	typedef logic [COMP_W-1:0]                    comp_t;
	typedef logic [DIM-1:0][COMP_W-1:0]           vec_t;
	typedef logic [DIM-1:0][DIM-1:0][COMP_W-1:0]  mat_t;
	typedef logic [DIM-1:0][DIM-1:0][PROD_W-1:0]  prod_mat_t;
	typedef logic [REG_W-1:0]                     cfg_word_t;
	typedef logic [IDX_W-1:0]                     cfg_idx_t;

	// identity, 1.0 fixed at bit 16
	localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
	};

	localparam comp_t OUT_MAX = 32'h7FFF_FFFF;
	localparam comp_t OUT_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

@@ rtl/core/vmt_if.sv @@
// Word channels for vertices in and transformed vertices out
`default_nettype none

interface vmt_in_if;
	import vmt_pkg::*;
	logic         valid;
	logic         ready;
	logic signed [COMP_W-1:0] in_x;
	logic signed [COMP_W-1:0] in_y;
	logic signed [COMP_W-1:0] in_z;
	logic signed [COMP_W-1:0] in_w;
	modport source (output valid, in_x, in_y, in_z, in_w, input ready);
	modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vmt_out_if;
	import vmt_pkg::*;
	logic         valid;
	logic         ready;
	logic signed [COMP_W-1:0] out_x;
	logic signed [COMP_W-1:0] out_y;
	logic signed [COMP_W-1:0] out_z;
	logic signed [COMP_W-1:0] out_w;
	logic         overflow;
	modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
	modport sink   (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vmt_cfg_regs.sv @@
// Matrix configuration registers
`default_nettype none

module vmt_cfg_regs
	import vmt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_wen,
	input  wire cfg_idx_t  cfg_index,
	input  wire cfg_word_t cfg_data,
	output mat_t           mat
);

	cfg_word_t cfg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				cfg_q[r] <= CFG_RESET[r];
			end
		end else if (cfg_wen) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				mat[i][j] = cfg_q[2 * i + j / 2][COMP_W * (j % 2) +: COMP_W];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/vmt_mult.sv @@
// Input register stage and 16 signed products
`default_nettype none

module vmt_mult
	import vmt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	vmt_in_if.sink     vertex,
	input  wire mat_t  mat,
	output logic       valid_s2,
	input  wire logic  ready_s2,
	output prod_mat_t  prod_s2
);

	logic valid_s1;
	vec_t vec_s1;
	logic adv_s1;
	logic adv_s2;

	assign adv_s2       = !valid_s2 || ready_s2;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign vertex.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= vertex.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vertex.valid) begin
			vec_s1 <= {vertex.in_w, vertex.in_z, vertex.in_y, vertex.in_x};
		end
		if (adv_s2 && valid_s1) begin
			for (int i = 0; i < DIM; i++) begin
				for (int j = 0; j < DIM; j++) begin
					prod_s2[i][j] <= $signed(vec_s1[i]) * $signed(mat[i][j]);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/vmt_accum.sv @@
// Column sums, fraction shift and saturation
`default_nettype none

module vmt_accum
	import vmt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      valid_s2,
	output logic           ready_s2,
	input  wire prod_mat_t prod_s2,
	vmt_out_if.source      result
);

	logic valid_s3, valid_s4, valid_s5;
	logic adv_s3, adv_s4, adv_s5;
	logic signed [PAIR_W-1:0] pair_a_s3 [DIM];
	logic signed [PAIR_W-1:0] pair_b_s3 [DIM];
	logic signed [SUM_W-1:0]  sum_s4    [DIM];
	logic signed [SUM_W-1:0]  full      [DIM];
	comp_t                    sat       [DIM];
	logic [DIM-1:0]           ovf;
	vec_t                     res_s5;
	logic                     ovf_s5;

	assign adv_s5   = !valid_s5 || result.ready;
	assign adv_s4   = !valid_s4 || adv_s5;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign ready_s2 = adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
		end
	end

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			full[j] = SUM_W'(pair_a_s3[j]) + SUM_W'(pair_b_s3[j]);
		end
	end

	// value fits in 32 bits when bits above 30 all match the sign
	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			if (!sum_s4[j][SUM_W-1] && |sum_s4[j][SUM_W-2:COMP_W-1]) begin
				sat[j] = OUT_MAX;
				ovf[j] = 1'b1;
			end else if (sum_s4[j][SUM_W-1] && !(&sum_s4[j][SUM_W-2:COMP_W-1])) begin
				sat[j] = OUT_MIN;
				ovf[j] = 1'b1;
			end else begin
				sat[j] = sum_s4[j][COMP_W-1:0];
				ovf[j] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			for (int j = 0; j < DIM; j++) begin
				pair_a_s3[j] <= PAIR_W'($signed(prod_s2[0][j])) + PAIR_W'($signed(prod_s2[1][j]));
				pair_b_s3[j] <= PAIR_W'($signed(prod_s2[2][j])) + PAIR_W'($signed(prod_s2[3][j]));
			end
		end
		if (adv_s4 && valid_s3) begin
			for (int j = 0; j < DIM; j++) begin
				sum_s4[j] <= full[j] >>> FRAC_BITS;
			end
		end
		if (adv_s5 && valid_s4) begin
			for (int j = 0; j < DIM; j++) begin
				res_s5[j] <= sat[j];
			end
			ovf_s5 <= |ovf;
		end
	end

	assign result.valid    = valid_s5;
	assign result.out_x    = res_s5[0];
	assign result.out_y    = res_s5[1];
	assign result.out_z    = res_s5[2];
	assign result.out_w    = res_s5[3];
	assign result.overflow = ovf_s5;

endmodule

`default_nettype wire

@@ rtl/core/vertex_matrix_transform.sv @@
// Top level: homogeneous vertex (row vector) times 4x4 fixed-point matrix
// Throughput: one vertex per cycle unless result.ready stalls the pipeline; five
// register stages (input, 16 multipliers, pair adds, final add and shift, saturate),
// each holding on its own stall.
// Reset: pipeline empties; the matrix returns to identity.
`default_nettype none

module vertex_matrix_transform
	import vmt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_wen,
	input  wire cfg_idx_t  cfg_index,
	input  wire cfg_word_t cfg_data,
	vmt_in_if.sink         vertex,
	vmt_out_if.source      result
);

	mat_t      mat;
	logic      valid_s2;
	logic      ready_s2;
	prod_mat_t prod_s2;

	vmt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mat       (mat)
	);

	vmt_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.vertex   (vertex),
		.mat      (mat),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.prod_s2  (prod_s2)
	);

	vmt_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.prod_s2  (prod_s2),
		.result   (result)
	);

endmodule

`default_nettype wire
